>>> rtl/gamepad_ascii_frame_parser_defines.svh
// Assertion macros used by the parser RTL.
`ifndef GAMEPAD_ASCII_FRAME_PARSER_DEFINES_SVH
`define GAMEPAD_ASCII_FRAME_PARSER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define GAFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gafp assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define GAFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gafp assertion failed");

`endif

>>> rtl/gafp_pkg.sv
package gafp_pkg;

  localparam logic [7:0] CR_BYTE    = 8'h0d;
  localparam logic [7:0] LF_BYTE    = 8'h0a;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] PLUS_BYTE  = 8'h2b;
  localparam logic [7:0] MINUS_BYTE = 8'h2d;
  localparam logic [7:0] POINT_BYTE = 8'h2e;
  localparam logic [7:0] ZERO_BYTE  = 8'h30;
  localparam logic [7:0] NINE_BYTE  = 8'h39;

  localparam int PAYLOAD_LEN = 32;
  localparam int FIELD_LEN   = 4;
  localparam int NUM_FIELDS  = PAYLOAD_LEN / FIELD_LEN;
  localparam int GROUP_LEN   = 4;
  localparam int VALUE_W     = 21;
  localparam int MAG_W       = 20;
  localparam int IDX_W       = $clog2(PAYLOAD_LEN);
  localparam int FIELD_IDX_W = $clog2(NUM_FIELDS);
  localparam int OUT_DATA_W  = 88;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [MAG_W-1:0] mag_t;

  // Whitespace as skipped before a number: space, TAB, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] c);
    return (c == SPACE_BYTE) || ((c >= TAB_BYTE) && (c <= CR_BYTE));
  endfunction

  // Convert one four-character field (first character in the low byte)
  // to hundredths, truncated toward zero; no digits gives zero.
  function automatic value_t conv_field(input logic [8*FIELD_LEN-1:0] f);
    mag_t       v;
    logic       neg;
    logic       pt;
    logic       any_d;
    logic       stop;
    logic       lead;
    logic [1:0] fc;
    logic [7:0] c;
    logic [3:0] d;
    v     = '0;
    neg   = 1'b0;
    pt    = 1'b0;
    any_d = 1'b0;
    stop  = 1'b0;
    lead  = 1'b1;
    fc    = '0;
    for (int k = 0; k < FIELD_LEN; k++) begin
      c = f[8*k +: 8];
      d = c[3:0];
      if (!stop) begin
        if (lead && is_space(c)) begin
          lead = 1'b1;
        end else if (lead && ((c == PLUS_BYTE) || (c == MINUS_BYTE))) begin
          neg  = (c == MINUS_BYTE);
          lead = 1'b0;
        end else begin
          lead = 1'b0;
          if ((c >= ZERO_BYTE) && (c <= NINE_BYTE)) begin
            any_d = 1'b1;
            if (!pt) begin
              v = MAG_W'(v * MAG_W'(10) + MAG_W'(d));
            end else if (fc < 2'd2) begin
              v  = (fc == 2'd0) ? MAG_W'(v + MAG_W'(d) * MAG_W'(10))
                                : MAG_W'(v + MAG_W'(d));
              fc = fc + 2'd1;
            end
          end else if ((c == POINT_BYTE) && !pt) begin
            pt = 1'b1;
            v  = MAG_W'(v * MAG_W'(100));
          end else begin
            stop = 1'b1;
          end
        end
      end
    end
    if (!any_d) begin
      v = '0;
    end else if (!pt) begin
      v = MAG_W'(v * MAG_W'(100));
    end
    return neg ? -value_t'({1'b0, v}) : value_t'({1'b0, v});
  endfunction

endpackage

>>> rtl/gamepad_ascii_frame_parser.sv
// Gamepad frame parser: takes one received byte per transfer and returns a
// result for each group of four decimal fields in a CR LF framed record. A
// byte is taken every cycle while in_tready is high; a transfer passes through
// one input register and one result register. Each field is converted as its
// fourth payload byte passes, so the two emitting bytes (the LF after the
// payload and the closing CR) only select stored values. in_tready drops only
// while a result waits in the result register, out_tready is low and the held
// byte would produce another result.
`include "gamepad_ascii_frame_parser_defines.svh"

module gamepad_ascii_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [20:0] value_a, [41:21] value_b,
                                  // [62:42] value_c, [83:63] value_d, zero pad
  output logic [0:0]  out_tuser   // [0] group
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LF1  = 3'd1;
  localparam logic [2:0] PH_PAY  = 3'd2;
  localparam logic [2:0] PH_LF2  = 3'd3;
  localparam logic [2:0] PH_WAIT = 3'd4;

  localparam int IDX_W = gafp_pkg::IDX_W;
  localparam int FW    = 8 * gafp_pkg::FIELD_LEN;

  // Input stage
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;

  // Frame state
  logic [2:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [FW-9:0]    buf_r;
  gafp_pkg::value_t val_r [gafp_pkg::NUM_FIELDS];

  // Result stage
  logic             out_valid_r;
  logic             out_group_r;
  gafp_pkg::value_t out_val_r [gafp_pkg::GROUP_LEN];

  logic             emit;
  logic             emit_grp;
  logic             adv;
  logic             conv_we;
  gafp_pkg::value_t conv_val;

  // Decide what the held byte does
  assign emit     = ((phase_r == PH_LF2) && (s1_byte_r == gafp_pkg::LF_BYTE)) ||
                    ((phase_r == PH_WAIT) && (s1_byte_r == gafp_pkg::CR_BYTE));
  assign emit_grp = (phase_r == PH_WAIT);
  assign adv      = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign conv_we  = adv && (phase_r == PH_PAY) && (idx_r[1:0] == 2'd3);
  assign conv_val = gafp_pkg::conv_field({s1_byte_r, buf_r});

  // Next frame phase and payload count
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    case (phase_r)
      PH_HUNT: begin
        phase_nxt = (s1_byte_r == gafp_pkg::CR_BYTE) ? PH_LF1 : PH_HUNT;
      end
      PH_LF1: begin
        if (s1_byte_r == gafp_pkg::LF_BYTE) begin
          idx_nxt   = '0;
          phase_nxt = PH_PAY;
        end else if (s1_byte_r != gafp_pkg::CR_BYTE) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_PAY: begin
        idx_nxt = IDX_W'(idx_r + 1'b1);
        if (idx_r == IDX_W'(gafp_pkg::PAYLOAD_LEN - 1)) begin
          phase_nxt = PH_LF2;
        end
      end
      PH_LF2: begin
        phase_nxt = (s1_byte_r == gafp_pkg::LF_BYTE) ? PH_WAIT : PH_HUNT;
      end
      PH_WAIT: begin
        if (s1_byte_r == gafp_pkg::CR_BYTE) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_HUNT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Shift payload bytes in and store each converted field
  always_ff @(posedge clk) begin
    if (adv && (phase_r == PH_PAY)) begin
      buf_r <= {s1_byte_r, buf_r[FW-9:8]};
    end
    if (conv_we) begin
      val_r[idx_r[IDX_W-1:2]] <= conv_val;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_group_r <= emit_grp;
      for (int j = 0; j < gafp_pkg::GROUP_LEN; j++) begin
        out_val_r[j] <= emit_grp ? val_r[gafp_pkg::GROUP_LEN + j] : val_r[j];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_group_r;
  assign out_tdata  = {4'b0, out_val_r[3], out_val_r[2], out_val_r[1], out_val_r[0]};

  `GAFP_ASSERT(a_ready_low_holds, !in_tready |-> s1_valid_r)
  `GAFP_ASSERT_NEXT(a_emit_loads, adv && emit, out_valid_r)
  `GAFP_ASSERT_NEXT(a_grp1_ends_frame, adv && emit && emit_grp, phase_r == PH_HUNT)
  `GAFP_ASSERT(a_idx_idle_zero, (phase_r != PH_PAY) |-> (idx_r == '0))

endmodule
